// ----- sv/tesp_pkg.sv -----
// Shared types, constants and screen geometry for the terminal escape sequence parser.
package tesp_pkg;

  localparam int COLS  = 80;
  localparam int ROWS  = 24;
  localparam int ROW_W = 5;
  localparam int COL_W = 7;
  localparam int CELL_W = 11;
  localparam int FWD_W = COL_W + 1;

  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_P         = 8'h50;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_ONE       = 8'h31;
  localparam logic [7:0] CH_TWO       = 8'h32;
  localparam logic [7:0] CH_SIX       = 8'h36;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_UP_H      = 8'h48;
  localparam logic [7:0] CH_UP_C      = 8'h43;
  localparam logic [7:0] CH_UP_K      = 8'h4B;
  localparam logic [7:0] CH_UP_J      = 8'h4A;
  localparam logic [7:0] CH_LO_H      = 8'h68;
  localparam logic [7:0] CH_LO_L      = 8'h6C;
  localparam logic [7:0] CH_LO_C      = 8'h63;
  localparam logic [7:0] CH_LO_R      = 8'h72;
  localparam logic [7:0] CH_LO_M      = 8'h6D;
  localparam logic [7:0] CH_LO_N      = 8'h6E;

  typedef enum logic [2:0] {
    ACT_CONSUMED = 3'd0,
    ACT_PASS     = 3'd1,
    ACT_ERASE    = 3'd2,
    ACT_CURSOR   = 3'd3,
    ACT_IGNORED  = 3'd4,
    ACT_ERROR    = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    K_DIRECT       = 3'd0,
    K_SET          = 3'd1,
    K_FWD          = 3'd2,
    K_ERASE_LINE   = 3'd3,
    K_ERASE_SCREEN = 3'd4
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ER_TO_END     = 2'd0,
    ER_FROM_START = 2'd1,
    ER_ALL        = 2'd2
  } erase_mode_t;

  typedef struct packed {
    cmd_kind_t          kind;
    act_t               action;
    logic [7:0]         echo;
    logic [ROW_W-1:0]   row_tgt;
    logic [COL_W-1:0]   col_tgt;
    logic [FWD_W-1:0]   fwd;
    erase_mode_t        mode;
  } cmd_t;

  typedef struct packed {
    act_t               action;
    logic [7:0]         echo;
    logic [CELL_W-1:0]  erase_first;
    logic [CELL_W-1:0]  erase_end;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } res_t;

endpackage

// ----- sv/tesp_front.sv -----
// Front end: accepts bytes, tracks the escape phase, scans CSI parameters and emits commands.
module tesp_front import tesp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_input_byte,
  output logic       full,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  typedef enum logic [4:0] {
    PH_GROUND  = 5'b00001,
    PH_ESC     = 5'b00010,
    PH_CSI     = 5'b00100,
    PH_DCS     = 5'b01000,
    PH_DCS_ESC = 5'b10000
  } phase_t;

  typedef enum logic [12:0] {
    SC_WS1   = 13'b0000000000001,
    SC_SG1P  = 13'b0000000000010,
    SC_SG1N  = 13'b0000000000100,
    SC_D1P   = 13'b0000000001000,
    SC_D1N   = 13'b0000000010000,
    SC_WS2   = 13'b0000000100000,
    SC_SG2P  = 13'b0000001000000,
    SC_SG2N  = 13'b0000010000000,
    SC_D2P   = 13'b0000100000000,
    SC_D2N   = 13'b0001000000000,
    SC_DEAD0 = 13'b0010000000000,
    SC_DEAD1 = 13'b0100000000000,
    SC_DEAD2 = 13'b1000000000000
  } scan_t;

  typedef enum logic [2:0] {
    PC_EMPTY = 3'd0,
    PC_ZERO  = 3'd1,
    PC_ONE   = 3'd2,
    PC_TWO   = 3'd3,
    PC_SIX   = 3'd4,
    PC_BAD   = 3'd5
  } pcode_t;

  phase_t             phase_r, phase_nxt;
  scan_t              scan_r, scan_nxt, scan_step;
  logic signed [15:0] first_r, first_nxt, first_step;
  logic signed [15:0] second_r, second_nxt, second_step;
  logic [1:0]         plen_r, plen_nxt;
  logic [7:0]         pchar_r, pchar_nxt;

  logic               accept;
  logic [7:0]         b;
  logic               ws, dig, is_final, cnt2, cnt_ge1;
  logic [3:0]         d;
  pcode_t             pc;
  logic signed [16:0] row_m1, col_m1;
  cmd_t               cmd;

  function automatic logic signed [15:0] add_digit(input logic signed [15:0] v,
                                                  input logic neg, input logic [3:0] dv);
    logic signed [20:0] ext;
    logic signed [20:0] p;
    logic signed [20:0] r;
    ext = 21'(v);
    p = (ext <<< 3) + (ext <<< 1);
    r = neg ? (p - $signed({17'd0, dv})) : (p + $signed({17'd0, dv}));
    if (r > 21'sd32767) begin
      r = 21'sd32767;
    end else if (r < -21'sd32768) begin
      r = -21'sd32768;
    end
    return r[15:0];
  endfunction

  assign b      = in_input_byte;
  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;
  assign q_cmd  = cmd;

  assign ws       = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign dig      = (b >= CH_ZERO) && (b <= CH_NINE);
  assign d        = b[3:0];
  assign is_final = (b >= CH_AT) && (b <= CH_TILDE);

  assign cnt2    = (scan_r == SC_D2P) || (scan_r == SC_D2N) || (scan_r == SC_DEAD2);
  assign cnt_ge1 = cnt2 || (scan_r == SC_D1P) || (scan_r == SC_D1N) || (scan_r == SC_WS2) ||
                   (scan_r == SC_SG2P) || (scan_r == SC_SG2N) || (scan_r == SC_DEAD1);

  always_comb begin
    if (plen_r == 2'd0) begin
      pc = PC_EMPTY;
    end else if (plen_r != 2'd1) begin
      pc = PC_BAD;
    end else if (pchar_r == CH_ZERO) begin
      pc = PC_ZERO;
    end else if (pchar_r == CH_ONE) begin
      pc = PC_ONE;
    end else if (pchar_r == CH_TWO) begin
      pc = PC_TWO;
    end else if (pchar_r == CH_SIX) begin
      pc = PC_SIX;
    end else begin
      pc = PC_BAD;
    end
  end

  always_comb begin
    scan_step   = scan_r;
    first_step  = first_r;
    second_step = second_r;
    case (scan_r)
      SC_WS1: begin
        if (!ws) begin
          if (b == CH_PLUS) begin
            scan_step = SC_SG1P;
          end else if (b == CH_MINUS) begin
            scan_step = SC_SG1N;
          end else if (dig) begin
            first_step = $signed({12'd0, d});
            scan_step  = SC_D1P;
          end else begin
            scan_step = SC_DEAD0;
          end
        end
      end
      SC_SG1P, SC_SG1N: begin
        if (dig) begin
          first_step = add_digit(16'sd0, scan_r == SC_SG1N, d);
          scan_step  = (scan_r == SC_SG1N) ? SC_D1N : SC_D1P;
        end else begin
          scan_step = SC_DEAD0;
        end
      end
      SC_D1P, SC_D1N: begin
        if (dig) begin
          first_step = add_digit(first_r, scan_r == SC_D1N, d);
        end else if (b == CH_SEMI) begin
          scan_step = SC_WS2;
        end else begin
          scan_step = SC_DEAD1;
        end
      end
      SC_WS2: begin
        if (!ws) begin
          if (b == CH_PLUS) begin
            scan_step = SC_SG2P;
          end else if (b == CH_MINUS) begin
            scan_step = SC_SG2N;
          end else if (dig) begin
            second_step = $signed({12'd0, d});
            scan_step   = SC_D2P;
          end else begin
            scan_step = SC_DEAD1;
          end
        end
      end
      SC_SG2P, SC_SG2N: begin
        if (dig) begin
          second_step = add_digit(16'sd0, scan_r == SC_SG2N, d);
          scan_step   = (scan_r == SC_SG2N) ? SC_D2N : SC_D2P;
        end else begin
          scan_step = SC_DEAD1;
        end
      end
      SC_D2P, SC_D2N: begin
        if (dig) begin
          second_step = add_digit(second_r, scan_r == SC_D2N, d);
        end else begin
          scan_step = SC_DEAD2;
        end
      end
      default: begin
        scan_step = scan_r;
      end
    endcase
  end

  assign row_m1 = 17'(first_r) - 17'sd1;
  assign col_m1 = 17'(second_r) - 17'sd1;

  always_comb begin
    phase_nxt  = phase_r;
    scan_nxt   = scan_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    plen_nxt   = plen_r;
    pchar_nxt  = pchar_r;
    cmd        = '0;
    cmd.kind   = K_DIRECT;
    cmd.action = ACT_CONSUMED;
    cmd.echo   = b;
    cmd.mode   = ER_TO_END;
    case (phase_r)
      PH_ESC: begin
        if (b == CH_LBRACKET) begin
          phase_nxt  = PH_CSI;
          first_nxt  = 16'sd0;
          second_nxt = 16'sd0;
          scan_nxt   = SC_WS1;
          plen_nxt   = 2'd0;
          pchar_nxt  = 8'd0;
        end else if (b == CH_P) begin
          phase_nxt = PH_DCS;
        end else begin
          cmd.action = (b == CH_EQUAL) ? ACT_IGNORED : ACT_ERROR;
          phase_nxt  = PH_GROUND;
        end
      end
      PH_CSI: begin
        if (is_final) begin
          phase_nxt = PH_GROUND;
          if (b == CH_UP_H) begin
            if (plen_r == 2'd0) begin
              cmd.kind    = K_SET;
              cmd.row_tgt = '0;
              cmd.col_tgt = '0;
            end else if (cnt2) begin
              cmd.kind = K_SET;
              if (row_m1 < 17'sd0) begin
                cmd.row_tgt = '0;
              end else if (row_m1 > $signed(17'(ROWS - 1))) begin
                cmd.row_tgt = ROW_W'(ROWS - 1);
              end else begin
                cmd.row_tgt = row_m1[ROW_W-1:0];
              end
              if (col_m1 < 17'sd0) begin
                cmd.col_tgt = '0;
              end else if (col_m1 > $signed(17'(COLS - 1))) begin
                cmd.col_tgt = COL_W'(COLS - 1);
              end else begin
                cmd.col_tgt = col_m1[COL_W-1:0];
              end
            end else begin
              cmd.action = ACT_ERROR;
            end
          end else if (b == CH_UP_C) begin
            cmd.kind = K_FWD;
            if (plen_r == 2'd0 || !cnt_ge1) begin
              cmd.fwd = FWD_W'(1);
            end else if (first_r > 16'sd0) begin
              if ($unsigned(first_r) >= 16'(COLS)) begin
                cmd.fwd = FWD_W'(COLS);
              end else begin
                cmd.fwd = first_r[FWD_W-1:0];
              end
            end else begin
              cmd.fwd = '0;
            end
          end else if (b == CH_UP_K || b == CH_UP_J) begin
            if (pc == PC_EMPTY || pc == PC_ZERO || pc == PC_ONE || pc == PC_TWO) begin
              cmd.kind = (b == CH_UP_K) ? K_ERASE_LINE : K_ERASE_SCREEN;
              if (pc == PC_ONE) begin
                cmd.mode = ER_FROM_START;
              end else if (pc == PC_TWO) begin
                cmd.mode = ER_ALL;
              end else begin
                cmd.mode = ER_TO_END;
              end
            end else begin
              cmd.action = ACT_ERROR;
            end
          end else if (b == CH_LO_H || b == CH_LO_L || b == CH_LO_C || b == CH_LO_R ||
                       b == CH_LO_M) begin
            cmd.action = ACT_IGNORED;
          end else if (b == CH_LO_N) begin
            cmd.action = (pc == PC_SIX) ? ACT_IGNORED : ACT_ERROR;
          end else begin
            cmd.action = ACT_ERROR;
          end
        end else begin
          if (plen_r == 2'd0) begin
            pchar_nxt = b;
          end
          if (plen_r != 2'd3) begin
            plen_nxt = plen_r + 2'd1;
          end
          scan_nxt   = scan_step;
          first_nxt  = first_step;
          second_nxt = second_step;
        end
      end
      PH_DCS: begin
        if (b == CH_ESC) begin
          phase_nxt = PH_DCS_ESC;
        end
      end
      PH_DCS_ESC: begin
        cmd.action = (b == CH_BACKSLASH) ? ACT_IGNORED : ACT_ERROR;
        phase_nxt  = PH_GROUND;
      end
      default: begin
        if (b == CH_ESC) begin
          phase_nxt = PH_ESC;
        end else begin
          cmd.action = ACT_PASS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GROUND;
      scan_r   <= SC_WS1;
      first_r  <= 16'sd0;
      second_r <= 16'sd0;
      plen_r   <= 2'd0;
      pchar_r  <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      scan_r   <= scan_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      plen_r   <= plen_nxt;
      pchar_r  <= pchar_nxt;
    end
  end

endmodule

// ----- sv/tesp_cmd_queue.sv -----
// Two-entry command queue between the front end and the back end.
module tesp_cmd_queue import tesp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- sv/tesp_back.sv -----
// Back end: applies commands to the cursor, computes erase ranges and queues the results.
module tesp_back import tesp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        out_action,
  output logic [7:0]        out_echo_byte,
  output logic [CELL_W-1:0] out_erase_first,
  output logic [CELL_W-1:0] out_erase_end,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [COL_W-1:0]  out_cursor_col
);

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  res_t              res_q_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        count_r, count_nxt;
  logic              take, do_pop;
  logic [CELL_W-1:0] line, here, line_end, total;
  logic [FWD_W-1:0]  col_sum;
  res_t              res;
  res_t              head;

  assign take    = !cmd_empty && (count_r != 2'd2);
  assign cmd_pop = take;
  assign empty   = (count_r == 2'd0);
  assign do_pop  = pop && !empty;

  assign line     = CELL_W'(row_r) * CELL_W'(COLS);
  assign here     = line + CELL_W'(col_r);
  assign line_end = line + CELL_W'(COLS);
  assign total    = CELL_W'(ROWS * COLS);
  assign col_sum  = FWD_W'(col_r) + cmd.fwd;

  always_comb begin
    row_nxt         = row_r;
    col_nxt         = col_r;
    res.action      = cmd.action;
    res.echo        = cmd.echo;
    res.erase_first = '0;
    res.erase_end   = '0;
    case (cmd.kind)
      K_SET: begin
        res.action = ACT_CURSOR;
        row_nxt    = cmd.row_tgt;
        col_nxt    = cmd.col_tgt;
      end
      K_FWD: begin
        res.action = ACT_CURSOR;
        if (col_sum > FWD_W'(COLS - 1)) begin
          col_nxt = COL_W'(COLS - 1);
        end else begin
          col_nxt = col_sum[COL_W-1:0];
        end
      end
      K_ERASE_LINE: begin
        res.action = ACT_ERASE;
        case (cmd.mode)
          ER_FROM_START: begin
            res.erase_first = line;
            res.erase_end   = here;
          end
          ER_ALL: begin
            res.erase_first = line;
            res.erase_end   = line_end;
          end
          default: begin
            res.erase_first = here;
            res.erase_end   = line_end;
          end
        endcase
      end
      K_ERASE_SCREEN: begin
        res.action = ACT_ERASE;
        case (cmd.mode)
          ER_FROM_START: begin
            res.erase_first = '0;
            res.erase_end   = here;
          end
          ER_ALL: begin
            res.erase_first = '0;
            res.erase_end   = total;
          end
          default: begin
            res.erase_first = here;
            res.erase_end   = total;
          end
        endcase
      end
      default: begin
        res.action = cmd.action;
      end
    endcase
    res.row = row_nxt;
    res.col = col_nxt;
  end

  assign count_nxt = count_r + {1'b0, take} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (take) begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q_r[wr_ptr_r] <= res;
    end
  end

  assign head            = res_q_r[rd_ptr_r];
  assign out_action      = head.action;
  assign out_echo_byte   = head.echo;
  assign out_erase_first = head.erase_first;
  assign out_erase_end   = head.erase_end;
  assign out_cursor_row  = head.row;
  assign out_cursor_col  = head.col;

endmodule

// ----- sv/terminal_escape_sequence_parser.sv -----
// Top level of the terminal escape sequence parser.
// The parser takes one byte per clock while full is low and returns one result per byte, in
// order. A front end tracks ESC, CSI and DCS phases and scans CSI parameters; a two-entry
// command queue feeds a back end that owns the cursor, computes erase ranges and holds results
// in a two-entry output queue. With pop held high, a new byte is accepted every cycle; a result
// reaches the out_ ports after its command is written into the command queue when its byte is
// accepted and then taken from there into the output queue.
// Stalls on the result side fill both queues before full is raised.
module terminal_escape_sequence_parser import tesp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_input_byte,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        out_action,
  output logic [7:0]        out_echo_byte,
  output logic [CELL_W-1:0] out_erase_first,
  output logic [CELL_W-1:0] out_erase_end,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [COL_W-1:0]  out_cursor_col
);

  logic q_full, q_push, q_empty, q_pop;
  cmd_t q_cmd_in, q_cmd_out;

  tesp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_input_byte (in_input_byte),
    .full          (full),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd_in)
  );

  tesp_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd_out),
    .empty (q_empty)
  );

  tesp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (q_empty),
    .cmd             (q_cmd_out),
    .cmd_pop         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .out_action      (out_action),
    .out_echo_byte   (out_echo_byte),
    .out_erase_first (out_erase_first),
    .out_erase_end   (out_erase_end),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col)
  );

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_cursor_row < ROW_W'(ROWS)) && (out_cursor_col < COL_W'(COLS)))
    else $error("cursor left the screen");

  a_erase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == ACT_ERASE) |->
      (out_erase_first <= out_erase_end) && (out_erase_end <= CELL_W'(ROWS * COLS)))
    else $error("erase range out of order or beyond the screen");

  a_no_range_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action != ACT_ERASE) |-> (out_erase_first == '0) && (out_erase_end == '0))
    else $error("erase range reported without an erase");

  a_cmd_enqueued: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && q_empty) |=> !q_empty)
    else $error("accepted transaction did not reach the command queue");

endmodule
